/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fdist_pkg.sv */
// ----------------------------------------------------------------------------
// fdist_pkg
// Types, constants and saturation helpers for the foldback distortion core.
// ----------------------------------------------------------------------------
`default_nettype none

package fdist_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int CTRL_W       = 16;
  localparam int MAX_FOLDS    = 100;
  localparam int FRAC_BITS    = 12;
  localparam int HALF_Q       = 1 << (FRAC_BITS - 1);

  localparam int V_W          = 24;   // internal Q11.12
  localparam int AMT_W        = 13;
  localparam int THR_W        = 13;
  localparam int AMOUNT_MAX   = 4096;
  localparam int THR_MIN      = 41;
  localparam int THR_MAX      = 4096;

  localparam int PROD_W       = SAMPLE_WIDTH + CTRL_W + 1;
  localparam int WIDE_W       = 64;
  localparam int CNT_W        = $clog2(MAX_FOLDS + 1);

  // fold engine datapath widths
  localparam int DP_W         = V_W + AMT_W;
  localparam int SW           = V_W + 4;

  localparam int Q_DEPTH      = 2;
  localparam int QPTR_W       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QLVL_W       = $clog2(Q_DEPTH + 1);

  localparam longint V_MAX = (longint'(1) <<< (V_W - 1)) - 1;
  localparam longint V_MIN = -V_MAX - 1;
  localparam longint S_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint S_MIN = -S_MAX - 1;

  typedef struct packed {
    logic signed [V_W-1:0] v;
    logic [AMT_W-1:0]      amt;
    logic [THR_W-1:0]      thr;
  } fdist_item_t;

  typedef struct packed {
    logic        valid;
    fdist_item_t item;
  } fdist_push_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QLVL_W-1:0] level;
  } fdist_qstat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FOLD,
    BK_OUT
  } bk_state_t;

  function automatic logic signed [V_W-1:0] sat_inner(input logic signed [WIDE_W-1:0] x);
    logic signed [V_W-1:0] r;
    if (x > V_MAX)      r = V_W'(V_MAX);
    else if (x < V_MIN) r = V_W'(V_MIN);
    else                r = V_W'(x);
    return r;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [WIDE_W-1:0] x
  );
    logic signed [SAMPLE_WIDTH-1:0] r;
    if (x > S_MAX)      r = SAMPLE_WIDTH'(S_MAX);
    else if (x < S_MIN) r = SAMPLE_WIDTH'(S_MIN);
    else                r = SAMPLE_WIDTH'(x);
    return r;
  endfunction

  function automatic logic [AMT_W-1:0] clamp_amt(input logic [CTRL_W-1:0] a);
    logic [AMT_W-1:0] r;
    if (a > CTRL_W'(AMOUNT_MAX)) r = AMT_W'(AMOUNT_MAX);
    else                         r = AMT_W'(a);
    return r;
  endfunction

  function automatic logic [THR_W-1:0] clamp_thr(input logic [CTRL_W-1:0] t);
    logic [THR_W-1:0] r;
    if (t < CTRL_W'(THR_MIN))      r = THR_W'(THR_MIN);
    else if (t > CTRL_W'(THR_MAX)) r = THR_W'(THR_MAX);
    else                           r = THR_W'(t);
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/fdist_front.sv */
// ----------------------------------------------------------------------------
// fdist_front
// Input stage: clamps amount and threshold, applies prescale gain and
// rounds the product into the internal format before queueing.
// ----------------------------------------------------------------------------
`default_nettype none

module fdist_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [fdist_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic [fdist_pkg::CTRL_W-1:0]         in_fold_amount,
  input  wire logic [fdist_pkg::CTRL_W-1:0]         in_pre_gain,
  input  wire logic [fdist_pkg::CTRL_W-1:0]         in_fold_threshold,
  output fdist_pkg::fdist_push_t                    push,
  input  wire fdist_pkg::fdist_qstat_t              qstat
);
  import fdist_pkg::*;

  logic                     fr_valid_r, fr_valid_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [AMT_W-1:0]         amt_r;
  logic [THR_W-1:0]         thr_r;
  logic                     accept, drain;
  logic signed [WIDE_W-1:0] rnd_wide;

  assign in_stall = fr_valid_r && qstat.full;
  assign accept   = in_valid && !in_stall;
  assign drain    = fr_valid_r && !qstat.full;

  assign prod_nxt = PROD_W'(in_sample) * PROD_W'(signed'({1'b0, in_pre_gain}));

  always_comb begin
    if (accept)     fr_valid_nxt = 1'b1;
    else if (drain) fr_valid_nxt = 1'b0;
    else            fr_valid_nxt = fr_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= prod_nxt;
      amt_r  <= clamp_amt(in_fold_amount);
      thr_r  <= clamp_thr(in_fold_threshold);
    end
  end

  // floor((p + half) / 4096) via arithmetic shift
  always_comb begin
    rnd_wide = (WIDE_W'(prod_r) + longint'(HALF_Q)) >>> FRAC_BITS;
  end

  always_comb begin
    push.valid    = fr_valid_r;
    push.item.v   = sat_inner(rnd_wide);
    push.item.amt = amt_r;
    push.item.thr = thr_r;
  end

endmodule

`default_nettype wire

/* rtl/fdist_queue.sv */
// ----------------------------------------------------------------------------
// fdist_queue
// Short FIFO decoupling the input stage from the fold engine.
// ----------------------------------------------------------------------------
`default_nettype none

module fdist_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire fdist_pkg::fdist_push_t push,
  input  wire logic                   pop,
  output fdist_pkg::fdist_item_t      q_item,
  output fdist_pkg::fdist_qstat_t     qstat
);
  import fdist_pkg::*;

  fdist_item_t       q_mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QLVL_W-1:0] lvl_r, lvl_nxt;
  logic              do_push, do_pop;

  assign qstat.full  = (lvl_r == QLVL_W'(Q_DEPTH));
  assign qstat.empty = (lvl_r == '0);
  assign qstat.level = lvl_r;

  assign do_push = push.valid && !qstat.full;
  assign do_pop  = pop && !qstat.empty;

  assign q_item = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    lvl_nxt    = lvl_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop)      lvl_nxt = lvl_r + 1'b1;
    else if (do_pop && !do_push) lvl_nxt = lvl_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      lvl_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      lvl_r    <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

`default_nettype wire

/* rtl/fdist_back.sv */
// ----------------------------------------------------------------------------
// fdist_back
// Fold engine: one fold step per cycle on the held value, then output
// saturation into a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdist_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire fdist_pkg::fdist_qstat_t              qstat,
  input  wire fdist_pkg::fdist_item_t               q_item,
  output logic                                      pop,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [fdist_pkg::SAMPLE_WIDTH-1:0] out_sample
);
  import fdist_pkg::*;

  bk_state_t                      st_r, st_nxt;
  logic signed [V_W-1:0]          v_r;
  logic [AMT_W-1:0]               amt_r;
  logic [THR_W-1:0]               thr_r;
  logic [CNT_W-1:0]               cnt_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r;

  logic                     q_valid, step, load_out, fold_end, d_pos;
  logic [V_W:0]             mag;
  logic signed [V_W+1:0]    d;
  logic [V_W-1:0]           d_u;
  logic [DP_W-1:0]          dprod;
  logic [DP_W:0]            dsum;
  logic [V_W+1:0]           e;
  logic signed [SW-1:0]     v_step;
  logic signed [V_W-1:0]    v_next;

  assign q_valid = !qstat.empty;

  // fold datapath
  always_comb begin
    mag    = v_r[V_W-1] ? ((V_W+1)'(0) - (V_W+1)'(v_r)) : (V_W+1)'(v_r);
    d      = signed'({1'b0, mag}) - signed'((V_W+2)'(thr_r));
    d_pos  = !d[V_W+1] && (d != '0);
    d_u    = d[V_W-1:0];
    dprod  = DP_W'(d_u) * DP_W'(amt_r);
    dsum   = (DP_W+1)'(dprod) + (DP_W+1)'(HALF_Q);
    e      = (V_W+2)'(d_u) + (V_W+2)'(dsum[DP_W:FRAC_BITS]);
    if (!v_r[V_W-1]) v_step = SW'(v_r) - signed'(SW'(e));
    else             v_step = SW'(v_r) + signed'(SW'(e));
    v_next = sat_inner(WIDE_W'(v_step));
  end

  assign fold_end = !d_pos || (cnt_r == CNT_W'(MAX_FOLDS));

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (q_valid)    st_nxt = BK_FOLD;
      BK_FOLD: if (fold_end)   st_nxt = BK_OUT;
      BK_OUT:  if (!out_stall) st_nxt = BK_IDLE;
      default:                 st_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    step      = 1'b0;
    load_out  = 1'b0;
    out_valid = 1'b0;
    unique case (st_r)
      BK_IDLE: pop = q_valid;
      BK_FOLD: begin
        step     = !fold_end;
        load_out = fold_end;
      end
      BK_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      v_r   <= q_item.v;
      amt_r <= q_item.amt;
      thr_r <= q_item.thr;
      cnt_r <= '0;
    end else if (step) begin
      v_r   <= v_next;
      cnt_r <= cnt_r + 1'b1;
    end
    if (load_out) begin
      out_r <= sat_sample(WIDE_W'(v_r));
    end
  end

  assign out_sample = out_r;

endmodule

`default_nettype wire

/* rtl/foldback_distortion_core.sv */
// Path: front register, queue, engine hold register, n fold steps (0..MAX_FOLDS),
// result register. The fold engine holds one sample, one fold step per cycle on a
// single multiplier, and pops the next only after its result leaves the output state.
// Input stage and two-entry queue keep taking beats while the engine folds.
// Reset: synchronous, active low; clears valids, queue pointers and engine state.
// ----------------------------------------------------------------------------
// foldback_distortion_core
// Prescale then foldback waveshaper on Q3.12 samples, saturated output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module foldback_distortion_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [fdist_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic [fdist_pkg::CTRL_W-1:0]         in_fold_amount,
  input  wire logic [fdist_pkg::CTRL_W-1:0]         in_pre_gain,
  input  wire logic [fdist_pkg::CTRL_W-1:0]         in_fold_threshold,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [fdist_pkg::SAMPLE_WIDTH-1:0] out_sample
);
  import fdist_pkg::*;

  fdist_push_t  push;
  fdist_qstat_t qstat;
  fdist_item_t  q_item;
  logic         pop;

  fdist_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_fold_amount    (in_fold_amount),
    .in_pre_gain       (in_pre_gain),
    .in_fold_threshold (in_fold_threshold),
    .push              (push),
    .qstat             (qstat)
  );

  fdist_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .q_item (q_item),
    .qstat  (qstat)
  );

  fdist_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .q_item     (q_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample)
  );

  // input only backs up when the queue is full
  `FD_ASSERT_IMP(a_stall_needs_full, in_stall, qstat.full, "in_stall without full queue")
  `FD_ASSERT_IMP(a_level_bound, 1'b1, qstat.level <= QLVL_W'(Q_DEPTH), "queue level overrun")
  // one result per sample: engine leaves the output state after a beat
  `FD_ASSERT_NXT(a_single_result, out_valid && !out_stall, !out_valid, "result repeated")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: foldback distortion core testbench
// Drives single-sample beats through the core and checks every output beat
// against the table's result or a behavioural fold model. Starts with a short
// directed table, then random samples under random input idles and output back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fdist_pkg::*;

  localparam int N_RANDOM   = 1900;
  localparam int IDLE_PCT   = 36;
  localparam int CYCLE_CAP  = 1_000_000;
  localparam int DRAIN_WAIT = MAX_FOLDS + 20;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic [CTRL_W-1:0]              amt;
    logic [CTRL_W-1:0]              gain;
    logic [CTRL_W-1:0]              thr;
    bit                             known;
    logic signed [SAMPLE_WIDTH-1:0] res;
  } fold_row_t;

  localparam int N_DIR = 19;

  // sample, amount, gain, threshold, result given, result
  fold_row_t dir_rows [N_DIR] = '{
    '{16'sd0,      16'd2048,  16'd4096,  16'd2048,  1'b1, 16'sd0},
    '{16'sd32767,  16'd2048,  16'd0,     16'd2048,  1'b1, 16'sd0},
    '{16'sd32767,  16'd0,     16'd4096,  16'd4096,  1'b1, 16'sd4096},
    '{16'sh8000,   16'd0,     16'd4096,  16'd4096,  1'b1, -16'sd4096},
    '{16'sd32767,  16'd0,     16'd4096,  16'd0,     1'b1, 16'sd41},
    '{16'sh8000,   16'd0,     16'd4096,  16'd40,    1'b1, -16'sd41},
    '{16'sd32767,  16'd0,     16'd65535, 16'd65535, 1'b1, 16'sd4096},
    '{16'sd1000,   16'd2048,  16'd4096,  16'd4096,  1'b1, 16'sd1000},
    '{-16'sd1,     16'd4096,  16'd4096,  16'd41,    1'b1, -16'sd1},
    '{16'sd2048,   16'd1,     16'd3,     16'd41,    1'b1, 16'sd2},
    '{-16'sd2048,  16'd0,     16'd3,     16'd41,    1'b1, -16'sd1},
    '{16'sd4096,   16'd4096,  16'd8192,  16'd4096,  1'b1, 16'sd0},
    '{16'sd4096,   16'd2048,  16'd4096,  16'd4096,  1'b1, 16'sd4096},
    '{16'sd41,     16'd4096,  16'd4096,  16'd0,     1'b1, 16'sd41},
    '{16'sd32767,  16'd65535, 16'd4096,  16'd4096,  1'b0, 16'sd0},
    '{16'sd32767,  16'd4096,  16'd65535, 16'd0,     1'b0, 16'sd0},
    '{16'sh8000,   16'd4096,  16'd65535, 16'd0,     1'b0, 16'sd0},
    '{16'sh8000,   16'd65535, 16'd65535, 16'd65535, 1'b0, 16'sd0},
    '{16'sd20000,  16'd1024,  16'd12000, 16'd3000,  1'b0, 16'sd0}
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic signed [SAMPLE_WIDTH-1:0] in_sample = '0;
  logic [CTRL_W-1:0]              in_fold_amount = '0;
  logic [CTRL_W-1:0]              in_pre_gain = '0;
  logic [CTRL_W-1:0]              in_fold_threshold = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;

  logic signed [SAMPLE_WIDTH-1:0] folded_q [$];
  int  n_errors = 0;
  int  n_cycles = 0;
  bit  calm = 1'b0;

  foldback_distortion_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_fold_amount    (in_fold_amount),
    .in_pre_gain       (in_pre_gain),
    .in_fold_threshold (in_fold_threshold),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // prescale, then fold back at the clamped threshold
  function automatic logic signed [SAMPLE_WIDTH-1:0] fold_sample(
    input logic signed [SAMPLE_WIDTH-1:0] smp,
    input logic [CTRL_W-1:0]              amt_raw,
    input logic [CTRL_W-1:0]              gain,
    input logic [CTRL_W-1:0]              thr_raw
  );
    longint amt, thr, v, mag, d, e;
    int     i;
    amt = (amt_raw > AMOUNT_MAX) ? longint'(AMOUNT_MAX) : longint'(amt_raw);
    if (thr_raw < THR_MIN)      thr = THR_MIN;
    else if (thr_raw > THR_MAX) thr = THR_MAX;
    else                        thr = longint'(thr_raw);
    // arithmetic shift gives floor division for negative products
    v = (longint'(smp) * longint'(gain) + HALF_Q) >>> FRAC_BITS;
    if (v > V_MAX) v = V_MAX;
    if (v < V_MIN) v = V_MIN;
    for (i = 0; i < MAX_FOLDS; i++) begin
      mag = (v < 0) ? -v : v;
      d = mag - thr;
      if (d <= 0) break;
      e = d + ((d * amt + HALF_Q) >>> FRAC_BITS);
      v = (v >= 0) ? v - e : v + e;
      if (v > V_MAX) v = V_MAX;
      if (v < V_MIN) v = V_MIN;
    end
    if (v > S_MAX) v = S_MAX;
    if (v < S_MIN) v = S_MIN;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  task automatic send_sample(input fold_row_t row);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_sample         <= row.smp;
    in_fold_amount    <= row.amt;
    in_pre_gain       <= row.gain;
    in_fold_threshold <= row.thr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (row.known) folded_q.insert(folded_q.size(), row.res);
    else folded_q.insert(folded_q.size(),
                         fold_sample(row.smp, row.amt, row.gain, row.thr));
  endtask

  // hold the input off until every outstanding beat has come back
  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (folded_q.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (folded_q.size() == 0) begin
        $display("%0t: unexpected out_sample beat, expected none, got %0d",
                 $time, out_sample);
        n_errors++;
      end else begin
        if (out_sample !== folded_q[0]) begin
          $display("%0t: out_sample mismatch, expected %0d, got %0d",
                   $time, folded_q[0], out_sample);
          n_errors++;
        end
        void'(folded_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_CAP) begin
      $display("foldback_distortion_core test failed");
      $finish;
    end
  end

  initial begin
    fold_row_t row;
    int        mode;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_DIR; k++) send_sample(dir_rows[k]);
    drain_outputs();

    for (int k = 0; k < N_RANDOM; k++) begin
      calm = (k >= 300 && k < 600);
      if (k == 1000) drain_outputs();
      mode = int'($urandom_range(99));
      row.smp   = SAMPLE_WIDTH'($urandom);
      row.known = 1'b0;
      row.res   = '0;
      if (mode < 65) begin
        // in-range controls, gain up to 4.0
        row.amt  = CTRL_W'($urandom_range(AMOUNT_MAX));
        row.gain = CTRL_W'($urandom_range(16384));
        row.thr  = CTRL_W'($urandom_range(THR_MAX, THR_MIN));
      end else begin
        row.amt  = CTRL_W'($urandom);
        row.gain = CTRL_W'($urandom);
        row.thr  = CTRL_W'($urandom);
      end
      send_sample(row);
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (folded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (n_errors == 0) begin
      $display("foldback_distortion_core test passed");
    end else begin
      $display("foldback_distortion_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
